/* src/iprt_pkg.sv */
// ----------------------------------------------------------------------------
// iprt_pkg: shared types and constants for the IPv4 route table
// Field widths, operation and status codes, payload structs, prefix mask.
// ----------------------------------------------------------------------------
`default_nettype none
package iprt_pkg;

    localparam int ADDR_W = 32;
    localparam int LEN_W  = 6;
    localparam int HOP_W  = 8;
    localparam int MAX_LEN = 32;

    localparam int DEF_TABLE_ENTRIES = 64;
    localparam int DEF_SLOT_COUNT    = 256;

    localparam logic [1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [1:0] FUNC_ADD    = 2'd1;
    localparam logic [1:0] FUNC_DEL    = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]        func;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  prefix_len;
        logic [HOP_W-1:0]  next_hop;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [HOP_W-1:0] slot;
    } rsp_t;

    // Classified command passed from front to back through the queue
    typedef struct packed {
        logic [1:0]        func;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  prefix_len;
        logic [HOP_W-1:0]  next_hop;
    } cmd_t;

    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
        logic [ADDR_W-1:0] m;
        m = '0;
        for (int b = 0; b < ADDR_W; b++)
        begin
            if (LEN_W'(ADDR_W - b) <= len)
            begin
                m[b] = 1'b1;
            end
        end
        return m;
    endfunction

endpackage
`default_nettype wire

/* src/ipv4_prefix_route_table_top.sv */
// ----------------------------------------------------------------------------
// ipv4_prefix_route_table_top: IPv4 longest-prefix-match route table
//
//   channel | direction | payload
//   in      | input     | req_t: func, address, prefix_len, next_hop
//   out     | output    | rsp_t: status, slot
//
// In the table each transaction compares across all entries, then does
// winner select and table update; one item in the table at a time. The
// compare vectors and then the result are registered. A 2-deep queue lets
// intake continue while out is stalled. Reset empties the table at once.
// ----------------------------------------------------------------------------
`default_nettype none
module ipv4_prefix_route_table_top #(
    parameter int TABLE_ENTRIES = iprt_pkg::DEF_TABLE_ENTRIES,
    parameter int SLOT_COUNT    = iprt_pkg::DEF_SLOT_COUNT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire iprt_pkg::req_t in_data,
    output logic                out_valid,
    input  wire logic           out_stall,
    output iprt_pkg::rsp_t      out_data
);
    import iprt_pkg::*;

    logic cmd_valid, cmd_take;
    cmd_t cmd_data;

    iprt_front #(.SLOT_COUNT(SLOT_COUNT)) u_front (
        .clk, .rst_n, .in_valid, .in_stall, .in_data,
        .cmd_valid, .cmd_take, .cmd_data
    );

    iprt_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
        .clk, .rst_n, .cmd_valid, .cmd_take, .cmd_data,
        .out_valid, .out_stall, .out_data
    );

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");
    a_take_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> cmd_valid)
        else $error("queue popped while empty");
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |=> !cmd_take)
        else $error("two items entered table back to back");
    a_full_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK |-> out_data.slot == '0)
        else $error("non-ok result carries a slot");
endmodule
`default_nettype wire

/* src/iprt_front.sv */
// ----------------------------------------------------------------------------
// iprt_front: request intake
// Saturates length and next hop, registers the command into a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none
module iprt_front #(
    parameter int SLOT_COUNT = 256
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire iprt_pkg::req_t in_data,
    output logic                cmd_valid,
    input  wire logic           cmd_take,
    output iprt_pkg::cmd_t      cmd_data
);
    import iprt_pkg::*;

    cmd_t       q_reg [2];
    cmd_t       q_next0;
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, rd_next;
    logic       push, pop;
    cmd_t       c;

    always_comb
    begin
        c.func       = in_data.func;
        c.address    = in_data.address;
        c.prefix_len = (in_data.prefix_len > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN)
                                                               : in_data.prefix_len;
        c.next_hop   = (int'(in_data.next_hop) > SLOT_COUNT - 1) ? HOP_W'(SLOT_COUNT - 1)
                                                                 : in_data.next_hop;
    end

    assign in_stall  = (cnt_reg == 2'd2);
    assign push      = in_valid && !in_stall;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop       = cmd_valid && cmd_take;
    assign cmd_data  = q_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
        rd_next  = pop ? !rd_reg : rd_reg;
        q_next0  = c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
        end
    end

    // write pointer = rd + count
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[rd_reg ^ cnt_reg[0]] <= q_next0;
        end
    end
endmodule
`default_nettype wire

/* src/iprt_back.sv */
// ----------------------------------------------------------------------------
// iprt_back: route table cell row
// All entries compare together (stage 1), winner picked in stage 2.
// ----------------------------------------------------------------------------
`default_nettype none
module iprt_back #(
    parameter int TABLE_ENTRIES = 64
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    output logic                cmd_take,
    input  wire iprt_pkg::cmd_t cmd_data,
    output logic                out_valid,
    input  wire logic           out_stall,
    output iprt_pkg::rsp_t      out_data
);
    import iprt_pkg::*;

    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int TREE_N = 1 << IDX_W;
    localparam int KEY_W  = LEN_W + ADDR_W;

    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [ADDR_W-1:0]        net_reg  [TABLE_ENTRIES];
    logic [LEN_W-1:0]         len_reg  [TABLE_ENTRIES];
    logic [HOP_W-1:0]         slot_reg [TABLE_ENTRIES];

    // stage 1 registered compare vectors
    logic                     s1_reg;
    cmd_t                     c_reg;
    logic [TABLE_ENTRIES-1:0] hit_reg, key_reg;
    logic                     ov_reg;
    rsp_t                     o_reg;

    logic [TABLE_ENTRIES-1:0] hit_c, key_c;
    logic                     busy;

    // one item in flight at a time; table update happens in stage 2
    assign busy     = s1_reg || (ov_reg && out_stall);
    assign cmd_take = cmd_valid && !busy;

    always_comb
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            hit_c[i] = valid_reg[i] &&
                ((net_reg[i] & prefix_mask(len_reg[i])) ==
                 (cmd_data.address & prefix_mask(len_reg[i])));
            key_c[i] = valid_reg[i] && net_reg[i] == cmd_data.address &&
                       len_reg[i] == cmd_data.prefix_len;
        end
    end

    // stage 2: winner tree over the hits; larger {len, ~net} wins, so the
    // longest prefix goes first and a tie goes to the lower network
    logic             tv [1:2*TREE_N-1];
    logic [KEY_W-1:0] tk [1:2*TREE_N-1];
    logic [HOP_W-1:0] ts [1:2*TREE_N-1];
    logic             best_f;
    logic [HOP_W-1:0] best_slot;
    always_comb
    begin
        for (int n = 1; n < 2*TREE_N; n++)
        begin
            tv[n] = 1'b0;
            tk[n] = '0;
            ts[n] = '0;
        end
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            tv[TREE_N+i] = hit_reg[i];
            tk[TREE_N+i] = {len_reg[i], ~net_reg[i]};
            ts[TREE_N+i] = slot_reg[i];
        end
        for (int n = TREE_N-1; n >= 1; n--)
        begin
            if (tv[2*n] && (!tv[2*n+1] || tk[2*n] > tk[2*n+1]))
            begin
                tv[n] = 1'b1;
                tk[n] = tk[2*n];
                ts[n] = ts[2*n];
            end
            else
            begin
                tv[n] = tv[2*n+1];
                tk[n] = tk[2*n+1];
                ts[n] = ts[2*n+1];
            end
        end
        best_f    = tv[1];
        best_slot = ts[1];
    end

    // stage 2: key match and first free entry
    logic             key_f, free_f;
    logic [IDX_W-1:0] key_i, free_i;
    always_comb
    begin
        key_f  = 1'b0; key_i  = '0;
        free_f = 1'b0; free_i = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (key_reg[i] && !key_f)
            begin
                key_f = 1'b1; key_i = IDX_W'(i);
            end
            if (!valid_reg[i] && !free_f)
            begin
                free_f = 1'b1; free_i = IDX_W'(i);
            end
        end
    end

    rsp_t             r;
    logic             wr_en, clr_en;
    logic [IDX_W-1:0] wr_i;
    always_comb
    begin
        r.status = ST_MISS;
        r.slot   = '0;
        wr_en    = 1'b0;
        clr_en   = 1'b0;
        wr_i     = key_f ? key_i : free_i;
        unique case (c_reg.func)
            FUNC_LOOKUP:
            begin
                if (best_f)
                begin
                    r.status = ST_OK;
                    r.slot   = best_slot;
                end
            end
            FUNC_ADD:
            begin
                if (key_f || free_f)
                begin
                    wr_en    = s1_reg;
                    r.status = ST_OK;
                    r.slot   = c_reg.next_hop;
                end
                else
                begin
                    r.status = ST_FULL;
                end
            end
            FUNC_DEL:
            begin
                if (key_f)
                begin
                    clr_en   = s1_reg;
                    r.status = ST_OK;
                end
            end
            default:
            begin
                r.status = ST_MISS;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            s1_reg    <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            s1_reg <= cmd_take;
            if (s1_reg)
            begin
                ov_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                ov_reg <= 1'b0;
            end
            if (wr_en)
            begin
                valid_reg[wr_i] <= 1'b1;
            end
            if (clr_en)
            begin
                valid_reg[key_i] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            c_reg   <= cmd_data;
            hit_reg <= hit_c;
            key_reg <= key_c;
        end
        if (s1_reg)
        begin
            o_reg <= r;
        end
        if (wr_en)
        begin
            net_reg[wr_i]  <= c_reg.address;
            len_reg[wr_i]  <= c_reg.prefix_len;
            slot_reg[wr_i] <= c_reg.next_hop;
        end
    end

    assign out_valid = ov_reg;
    assign out_data  = o_reg;
endmodule
`default_nettype wire

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: IPv4 route table checker
// Drives add, delete, lookup and unused-code transactions with random bursts and output
// stalls, predicts each response from a shadow route table, and compares it.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import iprt_pkg::*;

    localparam int ENTRIES    = DEF_TABLE_ENTRIES;
    localparam int LIMIT      = 400000;
    localparam int RAND_ITEMS = 1466;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    req_t in_data;
    logic out_valid;
    logic out_stall;
    rsp_t out_data;

    ipv4_prefix_route_table_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    // shadow route table
    logic              rt_valid [ENTRIES];
    logic [ADDR_W-1:0] rt_net   [ENTRIES];
    logic [LEN_W-1:0]  rt_len   [ENTRIES];
    logic [HOP_W-1:0]  rt_slot  [ENTRIES];

    rsp_t pending_rsp[$];
    int   error_count;
    int   cycle_count;
    bit   hold_off;

    // known routes for building well-formed traffic
    logic [ADDR_W-1:0] known_net[$];
    logic [LEN_W-1:0]  known_len[$];

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH t=%0t %s: got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic logic [ADDR_W-1:0] net_mask(input int len);
        if (len == 0)
            return '0;
        return {ADDR_W{1'b1}} << (ADDR_W - len);
    endfunction

    function automatic int find_route(input logic [ADDR_W-1:0] net, input int len);
        for (int i = 0; i < ENTRIES; i++)
            if (rt_valid[i] && rt_net[i] == net && rt_len[i] == len)
                return i;
        return -1;
    endfunction

    function automatic rsp_t route_apply(input req_t r);
        rsp_t res;
        int   len;
        int   idx;
        int   best;
        logic [ADDR_W-1:0] m;
        res.status = ST_MISS;
        res.slot   = '0;
        len = (r.prefix_len > MAX_LEN) ? MAX_LEN : r.prefix_len;
        idx = -1;
        best = -1;
        if (r.func == FUNC_LOOKUP)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (!rt_valid[i])
                    continue;
                m = net_mask(rt_len[i]);
                if ((rt_net[i] & m) != (r.address & m))
                    continue;
                if (best < 0 || rt_len[i] > rt_len[best] ||
                    (rt_len[i] == rt_len[best] && rt_net[i] < rt_net[best]))
                    best = i;
            end
            if (best >= 0)
            begin
                res.status = ST_OK;
                res.slot   = rt_slot[best];
            end
        end
        else if (r.func == FUNC_ADD)
        begin
            idx = find_route(r.address, len);
            if (idx < 0)
                for (int i = 0; i < ENTRIES; i++)
                    if (!rt_valid[i])
                    begin
                        idx = i;
                        break;
                    end
            if (idx < 0)
                res.status = ST_FULL;
            else
            begin
                rt_valid[idx] = 1'b1;
                rt_net[idx]   = r.address;
                rt_len[idx]   = LEN_W'(len);
                rt_slot[idx]  = r.next_hop;
                res.status    = ST_OK;
                res.slot      = r.next_hop;
            end
        end
        else if (r.func == FUNC_DEL)
        begin
            idx = find_route(r.address, len);
            if (idx >= 0)
            begin
                rt_valid[idx] = 1'b0;
                res.status    = ST_OK;
            end
        end
        return res;
    endfunction

    function automatic int live_routes();
        int n;
        n = 0;
        for (int i = 0; i < ENTRIES; i++)
            n += rt_valid[i];
        return n;
    endfunction

    // One transaction; burst gaps are inserted by the caller.
    task automatic send_item(input req_t r, input bit typed, input rsp_t want);
        rsp_t pred;
        in_valid <= 1'b1;
        in_data  <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pred = route_apply(r);
        if (typed && pred != want)
            report_mismatch("typed row vs predictor", pred, want);
        pending_rsp.push_back(typed ? want : pred);
        if (r.func == FUNC_ADD && pred.status == ST_OK)
        begin
            known_net.push_back(r.address);
            known_len.push_back(r.prefix_len);
        end
        @(negedge clk);
    endtask

    task automatic maybe_gap();
        int gap;
        if ($urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(negedge clk);
        end
    endtask

    function automatic req_t random_req();
        req_t r;
        int   k;
        int   pick;
        r.func       = 2'($urandom_range(0, 3));
        r.address    = $urandom;
        r.prefix_len = 6'($urandom_range(0, 63));
        r.next_hop   = 8'($urandom);
        if (r.prefix_len > 36 && $urandom_range(0, 5) != 0)
            r.prefix_len = 6'($urandom_range(0, 32));
        pick = $urandom_range(0, 9);
        if (known_net.size() > 0 && pick < 7)
        begin
            k = $urandom_range(0, known_net.size() - 1);
            if (r.func == FUNC_LOOKUP)
                r.address = (known_net[k] & net_mask(known_len[k] > 32 ? 32 : known_len[k]))
                            | (r.address & ~net_mask(known_len[k] > 32 ? 32 : known_len[k]));
            else if (r.func != FUNC_UNUSED)
            begin
                r.address    = known_net[k];
                r.prefix_len = known_len[k];
            end
        end
        // keep the table churning around full without dominating
        if (r.func == FUNC_ADD && live_routes() >= ENTRIES && $urandom_range(0, 3) != 0)
            r.func = FUNC_DEL;
        return r;
    endfunction

    // receiver stall pattern plus one long hold-off
    initial
    begin
        int hold;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                hold = 300;
                repeat (hold) @(negedge clk);
                hold_off = 1'b0;
            end
            case ($urandom_range(0, 2))
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                report_mismatch("unexpected response", out_data, 0);
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (out_data.status !== want.status)
                    report_mismatch("status", out_data.status, want.status);
                if (out_data.slot !== want.slot)
                    report_mismatch("slot", out_data.slot, want.slot);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    typedef struct {
        req_t r;
        bit   typed;
        rsp_t want;
    } row_t;

    function automatic row_t mk(input logic [1:0] f, input logic [31:0] a, input int l,
                                input int h, input bit t, input logic [1:0] s, input int sl);
        row_t x;
        x.r.func = f;
        x.r.address = a;
        x.r.prefix_len = 6'(l);
        x.r.next_hop = 8'(h);
        x.typed = t;
        x.want.status = s;
        x.want.slot = 8'(sl);
        return x;
    endfunction

    initial
    begin
        row_t dir_rows[$];
        req_t r;
        rsp_t none;
        error_count = 0;
        hold_off    = 1'b0;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        none     = '0;
        for (int i = 0; i < ENTRIES; i++)
            rt_valid[i] = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        dir_rows = '{
            mk(FUNC_LOOKUP, 32'hFFFF_FFFF, 0,  0,   1, ST_MISS, 0),  // empty table
            mk(FUNC_DEL,    32'h0A00_0000, 8,  0,   1, ST_MISS, 0),  // absent key
            mk(FUNC_UNUSED, 32'h0000_0000, 0,  0,   1, ST_MISS, 0),  // unused func
            mk(FUNC_ADD,    32'h0000_0000, 0,  7,   1, ST_OK,   7),  // default route
            mk(FUNC_LOOKUP, 32'hDEAD_BEEF, 0,  0,   1, ST_OK,   7),
            mk(FUNC_ADD,    32'h0A00_0000, 8,  255, 1, ST_OK,   255),
            mk(FUNC_ADD,    32'h0A01_0000, 16, 0,   1, ST_OK,   0),
            mk(FUNC_LOOKUP, 32'h0A01_0203, 0,  0,   0, ST_OK,   0),
            mk(FUNC_LOOKUP, 32'h0A02_0203, 0,  0,   0, ST_OK,   0),
            mk(FUNC_ADD,    32'hFFFF_FFFF, 63, 9,   1, ST_OK,   9),  // long prefix saturates
            mk(FUNC_LOOKUP, 32'hFFFF_FFFF, 0,  0,   0, ST_OK,   0),
            mk(FUNC_DEL,    32'hFFFF_FFFF, 32, 0,   1, ST_OK,   0),
            mk(FUNC_ADD,    32'h0A00_00FF, 8,  33,  1, ST_OK,   33), // low bits kept in key
            mk(FUNC_LOOKUP, 32'h0A99_0000, 0,  0,   0, ST_OK,   0),  // tie: lower network
            mk(FUNC_ADD,    32'h0A00_0000, 8,  44,  1, ST_OK,   44), // overwrite
            mk(FUNC_LOOKUP, 32'h0A99_0000, 0,  0,   0, ST_OK,   0),
            mk(FUNC_DEL,    32'h0A00_00FF, 8,  0,   1, ST_OK,   0),
            mk(FUNC_DEL,    32'h0000_0000, 0,  0,   1, ST_OK,   0),
            mk(FUNC_LOOKUP, 32'h0B00_0000, 0,  0,   1, ST_MISS, 0),
            mk(FUNC_UNUSED, 32'hFFFF_FFFF, 63, 255, 1, ST_MISS, 0)
        };
        @(negedge clk);
        foreach (dir_rows[i])
        begin
            send_item(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].want);
            maybe_gap();
        end

        // fill to capacity, then hit the full-table cases
        while (live_routes() < ENTRIES)
        begin
            r.func = FUNC_ADD;
            r.address = $urandom;
            r.prefix_len = 6'($urandom_range(0, 32));
            r.next_hop = 8'($urandom);
            send_item(r, 0, none);
            maybe_gap();
            if (live_routes() == 20)
                hold_off = 1'b1;
        end
        r.func = FUNC_ADD;
        r.address = 32'h0102_0304;
        r.prefix_len = 6'd33;
        r.next_hop = 8'd1;
        if (find_route(r.address, MAX_LEN) < 0)
            send_item(r, 1, '{status: ST_FULL, slot: 8'd0});
        r.address = known_net[known_net.size() - 1];
        r.prefix_len = known_len[known_len.size() - 1];
        r.next_hop = 8'd200;
        send_item(r, 0, none);  // overwrite on full table

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            send_item(random_req(), 0, none);
            maybe_gap();
        end
        in_valid <= 1'b0;

        while (pending_rsp.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
